[rtl/fpa_pkg.sv]
package fpa_pkg;

    localparam int KIND_W      = 1;
    localparam int SLOT_W      = 5;
    localparam int AMOUNT_W    = 16;
    localparam int FIT_MODE_W  = 2;
    localparam int BLK_COUNT_W = 6;
    localparam int REQ_NUM_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    // Placement policies. The unused code behaves as first fit.
    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic [FIT_MODE_W-1:0]  FIT_MODE_RESET    = FIT_FIRST;
    localparam logic [BLK_COUNT_W-1:0] BLOCK_COUNT_RESET = 6'd32;
    localparam logic [REQ_NUM_W-1:0]   REQ_NUM_MAX       = 8'd255;

endpackage

[rtl/fpa_size_mem.sv]
module fpa_size_mem #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fit_policy_partition_allocator_unit.sv]
// Load request: taken while idle, no result.
// Allocation request: the scan reads one size entry per cycle from a single memory port
// over the first min(block_count, NUM_BLOCKS) entries, then registers the result in the
// commit state. Input stalls until the commit, which out_stall on an earlier result delays.
// Reset clears the used marks and the request counter, sets the policy and block count
// registers to their reset values and clears the control state. The size memory is not
// cleared; the user must load every entry before use, which the block does not enforce.
module fit_policy_partition_allocator_unit #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fpa_pkg::KIND_W-1:0]           kind,
    input  logic [fpa_pkg::SLOT_W-1:0]           slot,
    input  logic [fpa_pkg::AMOUNT_W-1:0]         amount,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 granted,
    output logic [fpa_pkg::SLOT_W-1:0]           chosen_slot,
    output logic [fpa_pkg::REQ_NUM_W-1:0]        request_number,
    input  logic                                 cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = SIZE_BITS + fpa_pkg::AMOUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [fpa_pkg::FIT_MODE_W-1:0]     fit_mode_reg, fit_mode_next;
    logic [fpa_pkg::BLK_COUNT_W-1:0]    block_count_reg, block_count_next;
    logic [NUM_BLOCKS-1:0]              used_reg, used_next;
    logic [fpa_pkg::REQ_NUM_W-1:0]      counter_reg, counter_next;
    logic [fpa_pkg::AMOUNT_W-1:0]       amount_reg, amount_next;
    logic [CNT_W-1:0]                   limit_reg, limit_next;
    logic [CNT_W-1:0]                   rd_cnt_reg, rd_cnt_next;
    logic                               eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]                   eval_idx_reg, eval_idx_next;
    logic                               eval_used_reg, eval_used_next;
    logic                               found_reg, found_next;
    logic [IDX_W-1:0]                   pick_reg, pick_next;
    logic [SIZE_BITS-1:0]               pick_size_reg, pick_size_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               granted_reg, granted_next;
    logic [fpa_pkg::SLOT_W-1:0]         chosen_reg, chosen_next;
    logic [fpa_pkg::REQ_NUM_W-1:0]      req_num_reg, req_num_next;

    logic                               in_accept;
    logic                               slot_ok;
    logic [IDX_W-1:0]                   slot_idx;
    logic                               load_wr;
    logic                               rd_more;
    logic [IDX_W-1:0]                   rd_idx;
    logic [SIZE_BITS-1:0]               rd_size;
    logic                               eval_fits;
    logic                               take_pick;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_ok   = (32'(slot) < NUM_BLOCKS);
    assign slot_idx  = IDX_W'(slot);
    assign load_wr   = in_accept && (kind == fpa_pkg::KIND_LOAD) && slot_ok;
    assign rd_more   = (rd_cnt_reg < limit_reg);
    assign rd_idx    = rd_cnt_reg[IDX_W-1:0];

    fpa_size_mem #(
        .DEPTH  (NUM_BLOCKS),
        .WIDTH  (SIZE_BITS),
        .ADDR_W (IDX_W)
    ) u_size_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (slot_idx),
        .wr_data (SIZE_BITS'(amount)),
        .rd_en   ((state_reg == S_SCAN) && rd_more),
        .rd_addr (rd_idx),
        .rd_data (rd_size)
    );

    // Compare unit shared by every step of the scan.
    assign eval_fits = !eval_used_reg && (CMP_W'(rd_size) >= CMP_W'(amount_reg));

    always_comb
    begin
        take_pick = !found_reg;
        unique case (fit_mode_reg)
            fpa_pkg::FIT_BEST:  take_pick = !found_reg || (rd_size <= pick_size_reg);
            fpa_pkg::FIT_WORST: take_pick = !found_reg || (rd_size >= pick_size_reg);
            default:            take_pick = !found_reg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        fit_mode_next    = fit_mode_reg;
        block_count_next = block_count_reg;
        used_next        = used_reg;
        counter_next     = counter_reg;
        amount_next      = amount_reg;
        limit_next       = limit_reg;
        rd_cnt_next      = rd_cnt_reg;
        eval_valid_next  = eval_valid_reg;
        eval_idx_next    = eval_idx_reg;
        eval_used_next   = eval_used_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        pick_size_next   = pick_size_reg;
        out_valid_next   = out_valid_reg;
        granted_next     = granted_reg;
        chosen_next      = chosen_reg;
        req_num_next     = req_num_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                fpa_pkg::REG_FIT_MODE:    fit_mode_next = cfg_data[fpa_pkg::FIT_MODE_W-1:0];
                fpa_pkg::REG_BLOCK_COUNT: block_count_next = cfg_data;
                default:                  ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == fpa_pkg::KIND_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            used_next[slot_idx] = 1'b0;
                        end
                    end
                    else
                    begin
                        amount_next     = amount;
                        limit_next      = (32'(block_count_reg) > NUM_BLOCKS) ?
                                          CNT_W'(NUM_BLOCKS) : CNT_W'(block_count_reg);
                        rd_cnt_next     = '0;
                        eval_valid_next = 1'b0;
                        found_next      = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (eval_valid_reg && eval_fits && take_pick)
                begin
                    found_next     = 1'b1;
                    pick_next      = eval_idx_reg;
                    pick_size_next = rd_size;
                end
                // The read of one entry overlaps the compare of the previous one.
                if (rd_more)
                begin
                    eval_valid_next = 1'b1;
                    eval_idx_next   = rd_idx;
                    eval_used_next  = used_reg[rd_idx];
                    rd_cnt_next     = CNT_W'(rd_cnt_reg + 1'b1);
                end
                else
                begin
                    // The last entry is compared in this cycle, so the choice is final.
                    eval_valid_next = 1'b0;
                    state_next      = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = found_reg;
                    chosen_next    = found_reg ? fpa_pkg::SLOT_W'(pick_reg) : '0;
                    req_num_next   = counter_reg;
                    if (counter_reg != fpa_pkg::REQ_NUM_MAX)
                    begin
                        counter_next = counter_reg + 1'b1;
                    end
                    if (found_reg)
                    begin
                        used_next[pick_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fit_mode_reg    <= fpa_pkg::FIT_MODE_RESET;
            block_count_reg <= fpa_pkg::BLOCK_COUNT_RESET;
            used_reg        <= '0;
            counter_reg     <= '0;
            eval_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fit_mode_reg    <= fit_mode_next;
            block_count_reg <= block_count_next;
            used_reg        <= used_next;
            counter_reg     <= counter_next;
            amount_reg      <= amount_next;
            limit_reg       <= limit_next;
            rd_cnt_reg      <= rd_cnt_next;
            eval_valid_reg  <= eval_valid_next;
            eval_idx_reg    <= eval_idx_next;
            eval_used_reg   <= eval_used_next;
            found_reg       <= found_next;
            pick_reg        <= pick_next;
            pick_size_reg   <= pick_size_next;
            out_valid_reg   <= out_valid_next;
            granted_reg     <= granted_next;
            chosen_reg      <= chosen_next;
            req_num_reg     <= req_num_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign chosen_slot    = chosen_reg;
    assign request_number = req_num_reg;

endmodule

[rtl/fpa_checker.sv]
module fpa_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [fpa_pkg::KIND_W-1:0]           kind,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 granted,
    input logic [fpa_pkg::SLOT_W-1:0]           chosen_slot,
    input logic [fpa_pkg::REQ_NUM_W-1:0]        request_number
);

    // A pending result is not withdrawn while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted allocation request occupies the block on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == fpa_pkg::KIND_REQUEST) |=> in_stall)
        else $error("allocation request did not occupy the scanner");

    // A refused request reports block zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> (chosen_slot == '0))
        else $error("refused request carries a nonzero block");

    // Back-to-back results carry different ordinals until the counter saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=>
            !out_valid || (request_number != $past(request_number)) ||
            ($past(request_number) == fpa_pkg::REQ_NUM_MAX))
        else $error("request ordinal repeated");

endmodule

bind fit_policy_partition_allocator_unit fpa_checker u_fpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .chosen_slot    (chosen_slot),
    .request_number (request_number)
);

[tb/fpa_alloc_checker.sv]
`timescale 1ns / 1ps

module fpa_alloc_checker #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [fpa_pkg::KIND_W-1:0]       kind,
    input  logic [fpa_pkg::SLOT_W-1:0]       slot,
    input  logic [fpa_pkg::AMOUNT_W-1:0]     amount,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             granted,
    input  logic [fpa_pkg::SLOT_W-1:0]       chosen_slot,
    input  logic [fpa_pkg::REQ_NUM_W-1:0]    request_number,
    input  logic                             cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               mismatches,
    output int                               outstanding,
    output int                               results_seen,
    output int                               grants_seen
);

    typedef struct packed {
        logic                          granted;
        logic [fpa_pkg::SLOT_W-1:0]    slot;
        logic [fpa_pkg::REQ_NUM_W-1:0] number;
    } grant_t;

    grant_t                          awaited_grants[$];
    logic [SIZE_BITS-1:0]            part_size [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]           part_used;
    logic [fpa_pkg::FIT_MODE_W-1:0]  policy;
    logic [fpa_pkg::BLK_COUNT_W-1:0] scan_reg;
    logic [fpa_pkg::REQ_NUM_W-1:0]   ordinal;
    int                              err_count;
    int                              res_count;
    int                              grant_count;

    // Picks a partition for a request of the given size and marks it used.
    function automatic grant_t allocate(input logic [fpa_pkg::AMOUNT_W-1:0] want);
        grant_t               r;
        int                   limit;
        bit                   found;
        int                   pick;
        logic [SIZE_BITS-1:0] pick_size;
        limit     = (scan_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_reg);
        found     = 1'b0;
        pick      = 0;
        pick_size = '0;
        for (int i = 0; i < limit; i++)
        begin
            if (part_used[i] || part_size[i] < want)
                continue;
            if (!found)
            begin
                found     = 1'b1;
                pick      = i;
                pick_size = part_size[i];
            end
            // Ties go to the later block for both size-based policies.
            else if (policy == fpa_pkg::FIT_BEST && part_size[i] <= pick_size)
            begin
                pick      = i;
                pick_size = part_size[i];
            end
            else if (policy == fpa_pkg::FIT_WORST && part_size[i] >= pick_size)
            begin
                pick      = i;
                pick_size = part_size[i];
            end
        end
        if (found)
            part_used[pick] = 1'b1;
        r.granted = found;
        r.slot    = found ? fpa_pkg::SLOT_W'(pick) : '0;
        r.number  = ordinal;
        if (ordinal != fpa_pkg::REQ_NUM_MAX)
            ordinal++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t head;
        if (!rst_n)
        begin
            policy    = fpa_pkg::FIT_MODE_RESET;
            scan_reg  = fpa_pkg::BLOCK_COUNT_RESET;
            ordinal   = '0;
            part_used = '0;
            awaited_grants.delete();
            err_count   = 0;
            res_count   = 0;
            grant_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == fpa_pkg::REG_FIT_MODE)
                    policy = cfg_data[fpa_pkg::FIT_MODE_W-1:0];
                else if (cfg_index == fpa_pkg::REG_BLOCK_COUNT)
                    scan_reg = cfg_data[fpa_pkg::BLK_COUNT_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                res_count++;
                if (granted === 1'b1)
                    grant_count++;
                if (awaited_grants.size() == 0)
                begin
                    $error("result with no request pending: granted %0d slot %0d number %0d",
                           granted, chosen_slot, request_number);
                    err_count++;
                end
                else
                begin
                    head = awaited_grants.pop_front();
                    if (granted !== head.granted)
                    begin
                        $error("granted: expected %0d, got %0d", head.granted, granted);
                        err_count++;
                    end
                    if (chosen_slot !== head.slot)
                    begin
                        $error("chosen_slot: expected %0d, got %0d", head.slot, chosen_slot);
                        err_count++;
                    end
                    if (request_number !== head.number)
                    begin
                        $error("request_number: expected %0d, got %0d",
                               head.number, request_number);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == fpa_pkg::KIND_LOAD)
                begin
                    if (slot < NUM_BLOCKS)
                    begin
                        part_size[slot] = SIZE_BITS'(amount);
                        part_used[slot] = 1'b0;
                    end
                end
                else
                    awaited_grants.push_back(allocate(amount));
            end
        end
        mismatches   <= err_count;
        outstanding  <= awaited_grants.size();
        results_seen <= res_count;
        grants_seen  <= grant_count;
    end

endmodule

[tb/tb_fit_policy_partition_allocator_unit.sv]
`timescale 1ns / 1ps

module tb_fit_policy_partition_allocator_unit;

    localparam int NUM_BLOCKS   = 32;
    localparam int SIZE_BITS    = 16;
    localparam int RANDOM_ITEMS = 1250;
    // Longest scan plus commit, with margin.
    localparam int DRAIN_CYCLES = NUM_BLOCKS + 12;

    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             in_valid       = 1'b0;
    logic                             in_stall;
    logic [fpa_pkg::KIND_W-1:0]       kind           = fpa_pkg::KIND_LOAD;
    logic [fpa_pkg::SLOT_W-1:0]       slot           = '0;
    logic [fpa_pkg::AMOUNT_W-1:0]     amount         = '0;
    logic                             out_valid;
    logic                             out_stall      = 1'b0;
    logic                             granted;
    logic [fpa_pkg::SLOT_W-1:0]       chosen_slot;
    logic [fpa_pkg::REQ_NUM_W-1:0]    request_number;
    logic                             cfg_write      = 1'b0;
    logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index      = fpa_pkg::REG_FIT_MODE;
    logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data       = '0;

    int mismatches;
    int outstanding;
    int results_seen;
    int grants_seen;

    bit                           calm        = 1'b0;
    int                           stall_left  = 0;
    int                           scan_window;
    int                           load_count  = 0;
    int                           req_count   = 0;
    int                           phase_count = 0;
    logic [fpa_pkg::AMOUNT_W-1:0] loaded_amount [NUM_BLOCKS];

    fit_policy_partition_allocator_unit #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .slot          (slot),
        .amount        (amount),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .chosen_slot   (chosen_slot),
        .request_number(request_number),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fpa_alloc_checker #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .slot          (slot),
        .amount        (amount),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .chosen_slot   (chosen_slot),
        .request_number(request_number),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .grants_seen   (grants_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    always @(posedge clk)
    begin
        if (calm || !rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left <= gap_length() - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_item(input logic [fpa_pkg::KIND_W-1:0] k, input int s,
                             input logic [fpa_pkg::AMOUNT_W-1:0] a);
        int gap;
        gap = (calm || $urandom_range(99) < 60) ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        slot     <= fpa_pkg::SLOT_W'(s);
        amount   <= a;
        do
            @(posedge clk);
        while (in_stall);
        if (k == fpa_pkg::KIND_LOAD)
        begin
            load_count++;
            loaded_amount[s] = a;
        end
        else
            req_count++;
    endtask

    // Holds the sender off until every pending request has its result and the
    // block has had time to finish anything still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpa_pkg::CFG_DATA_W-1:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == fpa_pkg::REG_BLOCK_COUNT)
            scan_window = (data > NUM_BLOCKS) ? NUM_BLOCKS : int'(data);
    endtask

    function automatic logic [fpa_pkg::AMOUNT_W-1:0] load_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return fpa_pkg::AMOUNT_W'(16 * $urandom_range(1, 8));
        else if (roll < 70)
            return fpa_pkg::AMOUNT_W'($urandom_range(300));
        else if (roll < 90)
            return fpa_pkg::AMOUNT_W'($urandom_range(16'hFFFF));
        else if (roll < 95)
            return '0;
        else
            return '1;
    endfunction

    function automatic logic [fpa_pkg::AMOUNT_W-1:0] request_size();
        int                           roll;
        logic [fpa_pkg::AMOUNT_W-1:0] base;
        roll = $urandom_range(99);
        base = (scan_window > 0) ? loaded_amount[$urandom_range(scan_window - 1)]
                                 : fpa_pkg::AMOUNT_W'($urandom_range(300));
        if (roll < 45)
            return base;
        else if (roll < 60)
            return base + fpa_pkg::AMOUNT_W'($urandom_range(3))
                        - fpa_pkg::AMOUNT_W'($urandom_range(3));
        else if (roll < 80)
            return fpa_pkg::AMOUNT_W'($urandom_range(300));
        else if (roll < 95)
            return fpa_pkg::AMOUNT_W'($urandom_range(16'hFFFF));
        else
            return ($urandom_range(1) == 0) ? '0 : '1;
    endfunction

    initial
    begin
        int n_items;
        int random_sent;
        int roll;
        int s;

        scan_window = NUM_BLOCKS;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Every partition gets a size before the first request can scan it.
        // Sizes repeat every eight blocks so that best and worst fit see ties.
        for (int i = 0; i < NUM_BLOCKS - 2; i++)
            push_item(fpa_pkg::KIND_LOAD, i, fpa_pkg::AMOUNT_W'(16 * ((i % 8) + 1)));
        push_item(fpa_pkg::KIND_LOAD, NUM_BLOCKS - 2, '0);
        push_item(fpa_pkg::KIND_LOAD, NUM_BLOCKS - 1, '1);

        // Directed part, first fit from reset.
        push_item(fpa_pkg::KIND_REQUEST, 0, '0);
        push_item(fpa_pkg::KIND_REQUEST, 0, '1);
        push_item(fpa_pkg::KIND_REQUEST, 0, '1);
        push_item(fpa_pkg::KIND_LOAD, NUM_BLOCKS - 1, '1);
        push_item(fpa_pkg::KIND_REQUEST, 7, '1);
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(129));

        write_reg(fpa_pkg::REG_FIT_MODE, fpa_pkg::CFG_DATA_W'(fpa_pkg::FIT_BEST));
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(100));
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(1));

        write_reg(fpa_pkg::REG_FIT_MODE, fpa_pkg::CFG_DATA_W'(fpa_pkg::FIT_WORST));
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(1));
        push_item(fpa_pkg::KIND_REQUEST, 0, '0);

        // The unused policy code behaves as first fit.
        write_reg(fpa_pkg::REG_FIT_MODE, 6'b111111);
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(50));

        // Upper data bits are dropped; this selects best fit.
        write_reg(fpa_pkg::REG_FIT_MODE, 6'b111101);
        write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd0);
        push_item(fpa_pkg::KIND_REQUEST, 0, '0);

        write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd1);
        push_item(fpa_pkg::KIND_REQUEST, 0, '0);
        push_item(fpa_pkg::KIND_LOAD, 0, '0);
        push_item(fpa_pkg::KIND_REQUEST, 0, '0);

        write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd63);
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(120));

        // Writes to indexes with no register behind them must change nothing.
        write_reg(2'd2, 6'h3F);
        write_reg(2'd3, 6'h00);
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(10));
        push_item(fpa_pkg::KIND_REQUEST, 0, fpa_pkg::AMOUNT_W'(10));

        while (random_sent < RANDOM_ITEMS)
        begin
            phase_count++;
            calm <= 1'b0;
            write_reg(fpa_pkg::REG_FIT_MODE, fpa_pkg::CFG_DATA_W'($urandom_range(63)));
            roll = $urandom_range(9);
            case (roll)
                0:       write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd0);
                1:       write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd1);
                2:       write_reg(fpa_pkg::REG_BLOCK_COUNT, 6'd32);
                3:       write_reg(fpa_pkg::REG_BLOCK_COUNT,
                                   fpa_pkg::CFG_DATA_W'($urandom_range(33, 63)));
                4:       write_reg(fpa_pkg::REG_BLOCK_COUNT,
                                   fpa_pkg::CFG_DATA_W'($urandom_range(2, 4)));
                default: write_reg(fpa_pkg::REG_BLOCK_COUNT,
                                   fpa_pkg::CFG_DATA_W'($urandom_range(1, 32)));
            endcase
            calm <= ($urandom_range(5) == 0);
            n_items = $urandom_range(20, 60);
            for (int j = 0; j < n_items; j++)
            begin
                if ($urandom_range(99) < 45)
                begin
                    if (scan_window > 0 && $urandom_range(99) < 80)
                        s = $urandom_range(scan_window - 1);
                    else
                        s = $urandom_range(NUM_BLOCKS - 1);
                    push_item(fpa_pkg::KIND_LOAD, s, load_size());
                end
                else
                    push_item(fpa_pkg::KIND_REQUEST, $urandom_range(NUM_BLOCKS - 1),
                              request_size());
                random_sent++;
            end
        end

        settle();
        $display("summary: %0d loads and %0d requests over %0d random policy phases",
                 load_count, req_count, phase_count);
        $display("summary: %0d of %0d results granted", grants_seen, results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/fpa_pkg.sv
rtl/fpa_size_mem.sv
rtl/fit_policy_partition_allocator_unit.sv
rtl/fpa_checker.sv
tb/fpa_alloc_checker.sv
tb/tb_fit_policy_partition_allocator_unit.sv
